[src/sldc_pkg.sv]
// Shared types and constants for the sync/length frame command decoder.
package sldc_pkg;

  localparam int FRAME_BUFFER_BYTES = 64;
  localparam logic [7:0] RELEASE_PRESSURE = 8'd0;

  localparam int HEADER_BYTES = 3;
  localparam int TOUCH_BYTES = 5;
  localparam int FILL_W = $clog2(FRAME_BUFFER_BYTES + 1);
  localparam int TOUCH_IDX_W = $clog2(TOUCH_BYTES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    EV_PONG    = 4'd0,
    EV_KEY1    = 4'd1,
    EV_KEY2    = 4'd2,
    EV_DOWN    = 4'd3,
    EV_MOVE    = 4'd4,
    EV_UP      = 4'd5,
    EV_UNKNOWN = 4'd6,
    EV_SYNC    = 4'd7,
    EV_OVERRUN = 4'd8,
    EV_INVALID = 4'd9
  } event_t;

  typedef enum logic [2:0] {
    REG_SYNC_BYTE   = 3'd0,
    REG_PONG_CODE   = 3'd1,
    REG_KEY_ONE     = 3'd2,
    REG_KEY_TWO     = 3'd3,
    REG_TOUCH_DOWN  = 3'd4,
    REG_TOUCH_MOVE  = 3'd5,
    REG_TOUCH_UP    = 3'd6,
    REG_TOUCH_MIN   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_SYNC_ERR = 2'd0,
    JOB_INVALID  = 2'd1,
    JOB_OVERRUN  = 2'd2,
    JOB_FRAME    = 2'd3
  } job_kind_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] pong_code;
    logic [7:0] key_one_code;
    logic [7:0] key_two_code;
    logic [7:0] touch_down_code;
    logic [7:0] touch_move_code;
    logic [7:0] touch_up_code;
    logic [5:0] touch_min_payload;
  } cfg_t;

  typedef struct packed {
    job_kind_t                       kind;
    logic [7:0]                      cmd;
    logic                            short_payload;
    logic [TOUCH_BYTES-1:0][7:0]     touch;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[src/sync_length_frame_command_decoder_unit.sv]
// Top level of the sync/length framed command decoder.
// Takes one byte per cycle. The front end frames the stream (sync byte, 16-bit
// little-endian length, command, payload) and hands each sync error, invalid
// length, overrun or completed frame to a two-entry job queue; the back end
// decodes the command against the code registers into a registered result. A
// byte is accepted every cycle while the job queue has room; in_stall rises
// only when both queue entries are held behind a stalled result. Each result
// is queued, then registered. Short touch-down and touch-move frames yield
// no result. Configuration writes are always taken (cfg_ready is high).
module sync_length_frame_command_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          event_res,
  output logic [7:0]          command_code,
  output logic signed [15:0]  touch_x,
  output logic signed [15:0]  touch_y,
  output logic [7:0]          touch_pressure,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  sldc_pkg::cfg_t           cfg;
  sldc_pkg::job_t           push_job, head_job;
  sldc_pkg::queue_status_t  status;
  logic                     push, pop;

  assign cfg_ready = 1'b1;
  assign in_stall = status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte <= 8'd165;
      cfg.pong_code <= 8'd1;
      cfg.key_one_code <= 8'd2;
      cfg.key_two_code <= 8'd3;
      cfg.touch_down_code <= 8'd4;
      cfg.touch_move_code <= 8'd5;
      cfg.touch_up_code <= 8'd6;
      cfg.touch_min_payload <= 6'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (sldc_pkg::cfg_reg_t'(cfg_index))
        sldc_pkg::REG_SYNC_BYTE:  cfg.sync_byte <= cfg_data;
        sldc_pkg::REG_PONG_CODE:  cfg.pong_code <= cfg_data;
        sldc_pkg::REG_KEY_ONE:    cfg.key_one_code <= cfg_data;
        sldc_pkg::REG_KEY_TWO:    cfg.key_two_code <= cfg_data;
        sldc_pkg::REG_TOUCH_DOWN: cfg.touch_down_code <= cfg_data;
        sldc_pkg::REG_TOUCH_MOVE: cfg.touch_move_code <= cfg_data;
        sldc_pkg::REG_TOUCH_UP:   cfg.touch_up_code <= cfg_data;
        sldc_pkg::REG_TOUCH_MIN:  cfg.touch_min_payload <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  sldc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .cfg       (cfg),
    .push      (push),
    .job       (push_job)
  );

  sldc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (status)
  );

  sldc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head_job       (head_job),
    .status         (status),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .event_res      (event_res),
    .command_code   (command_code),
    .touch_x        (touch_x),
    .touch_y        (touch_y),
    .touch_pressure (touch_pressure)
  );

endmodule

[src/sldc_front.sv]
// Front end: frames the byte stream and classifies each completed frame or error.
module sldc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        data_byte,
  input  sldc_pkg::cfg_t    cfg,
  output logic              push,
  output sldc_pkg::job_t    job
);

  logic [sldc_pkg::FILL_W-1:0]              fill_count, fill_next, fill_inc;
  logic [15:0]                              length_field, length_next;
  logic [7:0]                               frame_command, command_next;
  logic [sldc_pkg::TOUCH_BYTES-1:0][7:0]    touch_bytes, touch_next;
  logic [5:0]                               need;
  logic [16:0]                              total;
  logic                                     accept;

  assign accept = in_valid && !in_stall;
  assign fill_inc = fill_count + 1'b1;
  assign need = (cfg.touch_min_payload < 6'(sldc_pkg::TOUCH_BYTES)) ?
                6'(sldc_pkg::TOUCH_BYTES) : cfg.touch_min_payload;
  assign total = {1'b0, length_next} + 17'(sldc_pkg::HEADER_BYTES);

  always_comb begin
    fill_next = fill_count;
    length_next = length_field;
    command_next = frame_command;
    touch_next = touch_bytes;
    push = 1'b0;
    job.kind = sldc_pkg::JOB_SYNC_ERR;
    job.cmd = command_next;
    job.short_payload = 1'b0;
    job.touch = touch_next;
    if (accept) begin
      if (fill_count == '0 && data_byte != cfg.sync_byte) begin
        push = 1'b1;
        job.kind = sldc_pkg::JOB_SYNC_ERR;
      end else if (fill_count >= sldc_pkg::FILL_W'(sldc_pkg::FRAME_BUFFER_BYTES)) begin
        fill_next = '0;
        push = 1'b1;
        job.kind = sldc_pkg::JOB_OVERRUN;
      end else begin
        if (fill_count == sldc_pkg::FILL_W'(1)) begin
          length_next[7:0] = data_byte;
        end else if (fill_count == sldc_pkg::FILL_W'(2)) begin
          length_next[15:8] = data_byte;
        end else if (fill_count == sldc_pkg::FILL_W'(3)) begin
          command_next = data_byte;
        end else if (fill_count >= sldc_pkg::FILL_W'(4) &&
                     fill_count < sldc_pkg::FILL_W'(4 + sldc_pkg::TOUCH_BYTES)) begin
          touch_next[sldc_pkg::TOUCH_IDX_W'(fill_count - sldc_pkg::FILL_W'(4))] = data_byte;
        end
        fill_next = fill_inc;
        job.cmd = command_next;
        job.touch = touch_next;
        job.short_payload = (length_next <= 16'(need));
        if (fill_inc >= sldc_pkg::FILL_W'(sldc_pkg::HEADER_BYTES)) begin
          if (length_next == '0 ||
              total > 17'(sldc_pkg::FRAME_BUFFER_BYTES)) begin
            fill_next = '0;
            push = 1'b1;
            job.kind = sldc_pkg::JOB_INVALID;
          end else if (17'(fill_inc) == total) begin
            fill_next = '0;
            push = 1'b1;
            job.kind = sldc_pkg::JOB_FRAME;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    length_field <= length_next;
    frame_command <= command_next;
    touch_bytes <= touch_next;
  end

endmodule

[src/sldc_queue.sv]
// Short job queue between the framing front end and the decode back end.
module sldc_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  sldc_pkg::job_t           push_job,
  input  logic                     pop,
  output sldc_pkg::job_t           head_job,
  output sldc_pkg::queue_status_t  status
);

  sldc_pkg::job_t                  entries [sldc_pkg::QUEUE_DEPTH];
  logic [sldc_pkg::QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [sldc_pkg::QUEUE_CW-1:0]   count;
  logic                            do_push, do_pop;

  assign status.full = (count == sldc_pkg::QUEUE_CW'(sldc_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == sldc_pkg::QUEUE_AW'(sldc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sldc_pkg::QUEUE_AW'(sldc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

[src/sldc_back.sv]
// Back end: decodes queued jobs into events and holds them in the output register.
module sldc_back (
  input  logic                     clk,
  input  logic                     rst,
  input  sldc_pkg::cfg_t           cfg,
  input  sldc_pkg::job_t           head_job,
  input  sldc_pkg::queue_status_t  status,
  output logic                     pop,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [3:0]               event_res,
  output logic [7:0]               command_code,
  output logic signed [15:0]       touch_x,
  output logic signed [15:0]       touch_y,
  output logic [7:0]               touch_pressure
);

  sldc_pkg::event_t  ev;
  logic              has_result;
  logic [7:0]        code;
  logic [15:0]       x, y;
  logic [7:0]        z;
  logic              is_touch;

  assign pop = !status.empty && (!out_valid || !out_stall);

  always_comb begin
    ev = sldc_pkg::EV_UNKNOWN;
    has_result = 1'b1;
    code = head_job.cmd;
    x = '0;
    y = '0;
    z = '0;
    is_touch = 1'b0;
    case (head_job.kind)
      sldc_pkg::JOB_SYNC_ERR: begin
        ev = sldc_pkg::EV_SYNC;
        code = '0;
      end
      sldc_pkg::JOB_INVALID: begin
        ev = sldc_pkg::EV_INVALID;
        code = '0;
      end
      sldc_pkg::JOB_OVERRUN: begin
        ev = sldc_pkg::EV_OVERRUN;
        code = '0;
      end
      sldc_pkg::JOB_FRAME: begin
        // first match wins when codes are shared
        if (head_job.cmd == cfg.pong_code) begin
          ev = sldc_pkg::EV_PONG;
        end else if (head_job.cmd == cfg.key_one_code) begin
          ev = sldc_pkg::EV_KEY1;
        end else if (head_job.cmd == cfg.key_two_code) begin
          ev = sldc_pkg::EV_KEY2;
        end else if (head_job.cmd == cfg.touch_down_code) begin
          ev = sldc_pkg::EV_DOWN;
          is_touch = 1'b1;
        end else if (head_job.cmd == cfg.touch_move_code) begin
          ev = sldc_pkg::EV_MOVE;
          is_touch = 1'b1;
        end else if (head_job.cmd == cfg.touch_up_code) begin
          ev = sldc_pkg::EV_UP;
          z = sldc_pkg::RELEASE_PRESSURE;
        end else begin
          ev = sldc_pkg::EV_UNKNOWN;
        end
        if (is_touch) begin
          x = {head_job.touch[1], head_job.touch[0]};
          y = {head_job.touch[3], head_job.touch[2]};
          z = head_job.touch[4];
          // drop touch-down and touch-move frames with too short a payload
          has_result = !head_job.short_payload;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      event_res <= ev;
      command_code <= code;
      touch_x <= x;
      touch_y <= y;
      touch_pressure <= z;
    end
  end

endmodule
